FILE: sv/buddy_allocator_treap_free_lists_core_assert.svh
// assertion macros for the buddy allocator core
// needs nothing else; included by the top level
`ifndef BUDDY_ALLOCATOR_TREAP_FREE_LISTS_CORE_ASSERT_SVH
`define BUDDY_ALLOCATOR_TREAP_FREE_LISTS_CORE_ASSERT_SVH

// same-cycle implication
`define BTA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bta assertion failed");

// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bta assertion failed");

`endif

FILE: sv/bta_pkg.sv
// shared constants, types and the node score function of the buddy allocator
// no dependencies
`timescale 1ns / 1ps

package bta_pkg;

   localparam int IDX_W      = 16;
   localparam int POOL       = 1 << IDX_W;
   localparam int NUM_CLS    = IDX_W + 1;
   localparam int CLS_W      = $clog2(NUM_CLS);
   localparam int WALK_LIMIT = IDX_W + 2;
   localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
   localparam int SCORE_W    = IDX_W + 2;
   localparam int POS_W      = IDX_W + 1;
   localparam int LINK_W     = 2 * IDX_W;
   localparam int POP_W      = $clog2(IDX_W + 1);

   typedef enum logic {
      CMD_ALLOC,
      CMD_FREE
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_TOO_LARGE,
      ST_NO_MEMORY
   } status_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic              en;
      logic [1:0]        mask;
      logic [IDX_W-1:0]  addr;
      logic [LINK_W-1:0] data;
   } ram_wr_type;

   // fixed treap priority of a node index
   function automatic logic [SCORE_W-1:0] score_of(input logic [IDX_W-1:0] n);
      logic [POS_W-1:0] val;
      logic [IDX_W-1:0] low;
      logic [POP_W-1:0] tz;
      logic [POP_W-1:0] pop;
      logic             found;
      val   = POS_W'(POOL) - {1'b0, n};
      low   = val[IDX_W-1:0];
      tz    = POP_W'(IDX_W);
      pop   = '0;
      found = 1'b0;
      for (int i = 0; i < IDX_W; i++) begin
         if (!found && low[i]) begin
            tz    = POP_W'(i);
            found = 1'b1;
         end
         pop = pop + POP_W'(low[i]);
      end
      return {1'b0, val} - SCORE_W'(pop) + (SCORE_W'(1) << tz);
   endfunction

endpackage

FILE: sv/bta_link_ram.sv
// child link memory: one word per node, left link low half, right link high
// uses bta_pkg; one write port with half enables, one registered read port
`timescale 1ns / 1ps

module bta_link_ram
   import bta_pkg::*;
(
   input  logic              clock,
   input  ram_rd_type        rd,
   input  ram_wr_type        wr,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] mem [POOL];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en && wr.mask[0]) begin
         mem[wr.addr][IDX_W-1:0] <= wr.data[IDX_W-1:0];
      end
      if (wr.en && wr.mask[1]) begin
         mem[wr.addr][LINK_W-1:IDX_W] <= wr.data[LINK_W-1:IDX_W];
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/buddy_allocator_treap_free_lists_core.sv
// buddy allocator over a pool of 65536 eight-byte nodes, free classes kept as treaps
// uses bta_pkg, bta_link_ram and the assertion macro header
// req channel: one word per command (allocate or free, byte count, block index);
//   accepted when req_valid is high and req_stall is low
// rsp channel: exactly one word per command, in order: granted index, status,
//   node and block totals after the command
// after reset the block stalls req while it clears the link memory, one entry
//   a cycle; class heads come up as node 2^i in class i below 16, class 16 empty
// a free of node zero or an oversized request goes straight to done; other items
//   walk treaps through the link memory, which has one read and one write port;
//   a walk is at most 18 steps and a command touches up to 17 classes
// one item is in work at a time; a new word is taken as soon as the previous
//   result sits in the rsp register, even while rsp_stall holds it
// when rsp_stall is high the finished result waits and the next one holds
//   in its done state until the register frees
`timescale 1ns / 1ps
`include "buddy_allocator_treap_free_lists_core_assert.svh"

module buddy_allocator_treap_free_lists_core
   import bta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_command,
   input  logic [15:0]      req_byte_count,
   input  logic [15:0]      req_block_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [15:0]      rsp_granted_index,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_used_nodes,
   output logic [15:0]      rsp_live_blocks
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_AFIND, S_ASPLIT, S_FLOOP, S_DONE,
      K_LOAD, K_STEP, K_RD, K_SW,
      I_START, I_CMP, I_RD, I_PLACE, I_ZERO,
      R_SET, R_RD, R_CP, R_GET, R_GOT, R_END,
      M_GET, M_WAIT, M_EVAL
   } state_type;

   // a link slot: a class head register or one half of a node's word
   typedef struct packed {
      logic             hd;
      logic [CLS_W-1:0] cls;
      logic [IDX_W-1:0] node;
      logic             side;
   } slot_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  heads_ff [NUM_CLS];
   logic [IDX_W-1:0]  heads_in [NUM_CLS];
   logic [15:0]       used_ff, used_in, live_ff, live_in;
   cmd_type           cmd_ff, cmd_in;
   status_type        status_ff, status_in;
   logic [CLS_W-1:0]  size_ff, size_in, cls_ff, cls_in;
   logic [IDX_W-1:0]  blk_ff, blk_in, tgt_ff, tgt_in;
   slot_type          slot_ff, slot_in, nslot_ff, nslot_in;
   logic [IDX_W-1:0]  node_ff, node_in, nn_ff, nn_in, pick_ff, pick_in;
   logic [SCORE_W-1:0] ns_ff, ns_in;
   logic [POS_W-1:0]  pos_ff, pos_in, level_ff, level_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_granted_index_ff, rsp_granted_index_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_used_nodes_ff, rsp_used_nodes_in;
   logic [15:0]       rsp_live_blocks_ff, rsp_live_blocks_in;

   ram_rd_type        ram_rd;
   ram_wr_type        ram_wr;
   logic [LINK_W-1:0] ram_rdata;
   logic [IDX_W-1:0]  rnode;

   bta_link_ram u_link_ram (
      .clock   (clock),
      .rd      (ram_rd),
      .wr      (ram_wr),
      .rd_data (ram_rdata)
   );

   // size class: bit length of nodes-1
   function automatic logic [CLS_W-1:0] class_of(input logic [15:0] bytes);
      logic [13:0]      nb;
      logic [CLS_W-1:0] len;
      nb  = 14'((17'(bytes) + 17'd7) >> 3);
      nb  = (nb != '0) ? nb - 14'd1 : '0;
      len = '0;
      for (int i = 0; i < 14; i++) begin
         if (nb[i]) begin
            len = CLS_W'(i + 1);
         end
      end
      return len;
   endfunction

   // link half that the current slot selects
   assign rnode = slot_ff.side ? ram_rdata[LINK_W-1:IDX_W] : ram_rdata[IDX_W-1:0];

   always_comb begin
      logic [IDX_W-1:0]  lnk_l, lnk_r, hnode;
      logic [POS_W-1:0]  lv;
      logic              side;
      logic [CLS_W-1:0]  sz, fcls;
      logic              fnd;
      logic              set_en;
      slot_type          set_slot;
      logic [IDX_W-1:0]  set_val;
      logic              wrd_en;
      logic [IDX_W-1:0]  wrd_addr;
      logic [LINK_W-1:0] wrd_data;
      logic              ins_go, ins_ret, sink_ret;
      logic [IDX_W-1:0]  ins_nn;
      logic [CLS_W-1:0]  ins_cls;

      state_in  = state_ff;
      clr_in    = clr_ff;
      heads_in  = heads_ff;
      used_in   = used_ff;
      live_in   = live_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      size_in   = size_ff;
      cls_in    = cls_ff;
      blk_in    = blk_ff;
      tgt_in    = tgt_ff;
      slot_in   = slot_ff;
      nslot_in  = nslot_ff;
      node_in   = node_ff;
      nn_in     = nn_ff;
      pick_in   = pick_ff;
      ns_in     = ns_ff;
      pos_in    = pos_ff;
      level_in  = level_ff;
      steps_in  = steps_ff;
      val_in    = val_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_granted_index_in = rsp_granted_index_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_used_nodes_in    = rsp_used_nodes_ff;
      rsp_live_blocks_in   = rsp_live_blocks_ff;

      ram_rd   = '0;
      lnk_l    = val_ff[IDX_W-1:0];
      lnk_r    = val_ff[LINK_W-1:IDX_W];
      hnode    = heads_ff[slot_ff.cls];
      lv       = level_ff >> 1;
      side     = 1'b0;
      sz       = class_of(req_byte_count);
      fcls     = '0;
      fnd      = 1'b0;
      set_en   = 1'b0;
      set_slot = slot_ff;
      set_val  = '0;
      wrd_en   = 1'b0;
      wrd_addr = '0;
      wrd_data = '0;
      ins_go   = 1'b0;
      ins_ret  = 1'b0;
      sink_ret = 1'b0;
      ins_nn   = '0;
      ins_cls  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wrd_en   = 1'b1;
            wrd_addr = clr_ff;
            clr_in   = clr_ff + IDX_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               size_in   = sz;
               blk_in    = req_block_index;
               status_in = ST_OK;
               if (sz > CLS_W'(IDX_W)) begin
                  status_in = ST_TOO_LARGE;
                  state_in  = S_DONE;
               end else if (cmd_type'(req_command) == CMD_ALLOC) begin
                  state_in = S_AFIND;
               end else if (req_block_index == '0) begin
                  state_in = S_DONE;
               end else begin
                  used_in  = 16'({1'b0, used_ff} - (17'd1 << sz));
                  live_in  = live_ff - 16'd1;
                  state_in = S_FLOOP;
               end
            end
         end
         S_AFIND: begin
            // smallest non-empty class at or above the request
            for (int c = 0; c < NUM_CLS; c++) begin
               if (!fnd && CLS_W'(c) >= size_ff && heads_ff[c] != '0) begin
                  fnd  = 1'b1;
                  fcls = CLS_W'(c);
               end
            end
            if (!fnd) begin
               status_in = ST_NO_MEMORY;
               state_in  = S_DONE;
            end else begin
               cls_in      = fcls;
               blk_in      = heads_ff[fcls];
               ram_rd.en   = 1'b1;
               ram_rd.addr = heads_ff[fcls];
               slot_in     = slot_type'{hd: 1'b1, cls: fcls, node: '0, side: 1'b0};
               state_in    = K_LOAD;
            end
         end
         S_ASPLIT: begin
            // hand the unused upper halves back, one class down each time
            if (cls_ff != size_ff) begin
               cls_in  = cls_ff - CLS_W'(1);
               ins_go  = 1'b1;
               ins_cls = cls_ff - CLS_W'(1);
               ins_nn  = blk_ff + (IDX_W'(1) << (cls_ff - CLS_W'(1)));
            end else begin
               used_in  = used_ff + (16'd1 << size_ff);
               live_in  = live_ff + 16'd1;
               state_in = S_DONE;
            end
         end
         S_FLOOP: begin
            if (size_ff < CLS_W'(IDX_W)) begin
               tgt_in   = blk_ff ^ (IDX_W'(1) << size_ff);
               slot_in  = slot_type'{hd: 1'b1, cls: size_ff, node: '0, side: 1'b0};
               pos_in   = '0;
               level_in = POS_W'(POOL);
               steps_in = '0;
               state_in = M_GET;
            end else begin
               ins_go  = 1'b1;
               ins_cls = size_ff;
               ins_nn  = blk_ff;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_granted_index_in = (cmd_ff == CMD_ALLOC && status_ff == ST_OK) ?
                                      blk_ff : '0;
               rsp_status_in        = status_ff;
               rsp_used_nodes_in    = used_ff;
               rsp_live_blocks_in   = live_ff;
               state_in             = S_IDLE;
            end
         end

         // remove the node whose links are in val from slot
         K_LOAD: begin
            val_in   = ram_rdata;
            steps_in = '0;
            state_in = K_STEP;
         end
         K_STEP: begin
            if (steps_ff == STEP_W'(WALK_LIMIT)) begin
               set_en   = 1'b1;
               set_val  = '0;
               sink_ret = 1'b1;
            end else if (lnk_l == '0) begin
               set_en   = 1'b1;
               set_val  = lnk_r;
               pick_in  = lnk_r;
               nslot_in = slot_type'{hd: 1'b0, cls: '0, node: lnk_r, side: 1'b1};
               if (lnk_r == '0) begin
                  sink_ret = 1'b1;
               end else begin
                  state_in = K_RD;
               end
            end else if (lnk_r == '0 || score_of(lnk_l) >= score_of(lnk_r)) begin
               set_en   = 1'b1;
               set_val  = lnk_l;
               pick_in  = lnk_l;
               nslot_in = slot_type'{hd: 1'b0, cls: '0, node: lnk_l, side: 1'b0};
               state_in = K_RD;
            end else begin
               set_en   = 1'b1;
               set_val  = lnk_r;
               pick_in  = lnk_r;
               nslot_in = slot_type'{hd: 1'b0, cls: '0, node: lnk_r, side: 1'b1};
               state_in = K_RD;
            end
         end
         K_RD: begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = pick_ff;
            state_in    = K_SW;
         end
         K_SW: begin
            // swap the carried links into the picked child
            wrd_en   = 1'b1;
            wrd_addr = pick_ff;
            wrd_data = val_ff;
            val_in   = ram_rdata;
            slot_in  = nslot_ff;
            steps_in = steps_ff + STEP_W'(1);
            state_in = K_STEP;
         end

         // insert nn into the treap whose head slot is set up
         I_START: begin
            if (hnode == '0) begin
               state_in = I_PLACE;
            end else begin
               node_in  = hnode;
               ns_in    = score_of(nn_ff);
               state_in = I_CMP;
            end
         end
         I_CMP: begin
            if (score_of(node_ff) < ns_ff) begin
               steps_in = '0;
               state_in = R_SET;
            end else begin
               side        = {1'b0, nn_ff} >= pos_ff;
               slot_in     = slot_type'{hd: 1'b0, cls: '0, node: node_ff, side: side};
               pos_in      = side ? pos_ff + lv : pos_ff - lv;
               level_in    = lv;
               ram_rd.en   = 1'b1;
               ram_rd.addr = node_ff;
               steps_in    = steps_ff + STEP_W'(1);
               state_in    = I_RD;
            end
         end
         I_RD: begin
            if (rnode == '0 || steps_ff == STEP_W'(WALK_LIMIT)) begin
               state_in = I_PLACE;
            end else begin
               node_in  = rnode;
               state_in = I_CMP;
            end
         end
         I_PLACE: begin
            set_en   = 1'b1;
            set_val  = nn_ff;
            state_in = I_ZERO;
         end
         I_ZERO: begin
            wrd_en   = 1'b1;
            wrd_addr = nn_ff;
            ins_ret  = 1'b1;
         end
         // push the lower-priority node down in place of the new one
         R_SET: begin
            set_en  = 1'b1;
            set_val = nn_ff;
            if (node_ff == '0) begin
               state_in = I_ZERO;
            end else begin
               state_in = R_RD;
            end
         end
         R_RD: begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = node_ff;
            state_in    = R_CP;
         end
         R_CP: begin
            wrd_en   = 1'b1;
            wrd_addr = nn_ff;
            wrd_data = ram_rdata;
            side     = {1'b0, node_ff} >= pos_ff;
            slot_in  = slot_type'{hd: 1'b0, cls: '0, node: nn_ff, side: side};
            pos_in   = side ? pos_ff + lv : pos_ff - lv;
            level_in = lv;
            nn_in    = node_ff;
            state_in = R_GET;
         end
         R_GET: begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = slot_ff.node;
            state_in    = R_GOT;
         end
         R_GOT: begin
            node_in  = rnode;
            steps_in = steps_ff + STEP_W'(1);
            if (steps_ff + STEP_W'(1) == STEP_W'(WALK_LIMIT)) begin
               state_in = R_END;
            end else begin
               state_in = R_SET;
            end
         end
         R_END: begin
            set_en  = 1'b1;
            set_val = '0;
            ins_ret = 1'b1;
         end

         // look for the buddy tgt in the class of the head slot
         M_GET: begin
            if (steps_ff == STEP_W'(WALK_LIMIT)) begin
               ins_go  = 1'b1;
               ins_cls = size_ff;
               ins_nn  = blk_ff;
            end else if (slot_ff.hd) begin
               node_in  = hnode;
               state_in = M_EVAL;
            end else begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = slot_ff.node;
               state_in    = M_WAIT;
            end
         end
         M_WAIT: begin
            node_in  = rnode;
            state_in = M_EVAL;
         end
         M_EVAL: begin
            if (node_ff == '0 || (node_ff != tgt_ff && {1'b0, tgt_ff} == pos_ff)) begin
               ins_go  = 1'b1;
               ins_cls = size_ff;
               ins_nn  = blk_ff;
            end else if (node_ff == tgt_ff) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = tgt_ff;
               state_in    = K_LOAD;
            end else begin
               side     = {1'b0, tgt_ff} >= pos_ff;
               slot_in  = slot_type'{hd: 1'b0, cls: '0, node: node_ff, side: side};
               pos_in   = side ? pos_ff + lv : pos_ff - lv;
               level_in = lv;
               steps_in = steps_ff + STEP_W'(1);
               state_in = M_GET;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of a sink: back to the split, or merge one level up
      if (sink_ret) begin
         if (cmd_ff == CMD_ALLOC) begin
            state_in = S_ASPLIT;
         end else begin
            blk_in   = blk_ff & ~(IDX_W'(1) << size_ff);
            size_in  = size_ff + CLS_W'(1);
            state_in = S_FLOOP;
         end
      end

      if (ins_ret) begin
         state_in = (cmd_ff == CMD_ALLOC) ? S_ASPLIT : S_DONE;
      end

      if (ins_go) begin
         nn_in    = ins_nn;
         slot_in  = slot_type'{hd: 1'b1, cls: ins_cls, node: '0, side: 1'b0};
         pos_in   = '0;
         level_in = POS_W'(POOL);
         steps_in = '0;
         state_in = I_START;
      end

      // a slot write goes to a head register or to one half of a link word
      if (set_en && set_slot.hd) begin
         heads_in[set_slot.cls] = set_val;
      end
      ram_wr.en   = wrd_en || (set_en && !set_slot.hd);
      ram_wr.mask = wrd_en ? 2'b11 : (set_slot.side ? 2'b10 : 2'b01);
      ram_wr.addr = wrd_en ? wrd_addr : set_slot.node;
      ram_wr.data = wrd_en ? wrd_data : {set_val, set_val};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLS; i++) begin
            heads_ff[i] <= (i < IDX_W) ? IDX_W'(1) << i : '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      cmd_ff               <= cmd_in;
      status_ff            <= status_in;
      size_ff              <= size_in;
      cls_ff               <= cls_in;
      blk_ff               <= blk_in;
      tgt_ff               <= tgt_in;
      slot_ff              <= slot_in;
      nslot_ff             <= nslot_in;
      node_ff              <= node_in;
      nn_ff                <= nn_in;
      pick_ff              <= pick_in;
      ns_ff                <= ns_in;
      pos_ff               <= pos_in;
      level_ff             <= level_in;
      val_ff               <= val_in;
      rsp_granted_index_ff <= rsp_granted_index_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_used_nodes_ff    <= rsp_used_nodes_in;
      rsp_live_blocks_ff   <= rsp_live_blocks_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_index_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_used_nodes    = rsp_used_nodes_ff;
   assign rsp_live_blocks   = rsp_live_blocks_ff;

   // an accepted word always starts work
   `BTA_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   // a failed command never reports a grant
   `BTA_ASSERT_SAME(a_fail_no_grant, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_granted_index_ff == '0)
   // treap walks stay within their step bound
   `BTA_ASSERT_SAME(a_walk_bound, clock, reset, state_ff != S_CLEAR, steps_ff <= STEP_W'(WALK_LIMIT))

endmodule
